// File: sv/klcam_pkg.sv
// Shared constants, types and codes of the key list table.
// No dependencies; every other file of the block imports this package.
package klcam_pkg;

   // Table geometry
   localparam int MAX_ENTRIES = 8;
   localparam int MAX_TOKENS  = 4;
   localparam int IN_TOKENS   = 4;
   localparam int TOKEN_W     = 64;
   localparam int SLOT_W      = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int LEN_W       = 3;
   localparam int OUT_SLOT_W  = 3;
   // Longest key length that a 3 bit count can carry after saturation
   localparam int LEN_SAT     = (MAX_TOKENS > 7) ? 7 : MAX_TOKENS;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   typedef logic [MAX_TOKENS-1:0][TOKEN_W-1:0] key_type;

   // Packet that walks the row of cells, one cell per cycle
   typedef struct packed {
      logic                valid;
      action_type          action;
      logic [LEN_W-1:0]    len;
      key_type             tokens;
      logic [SLOT_W-1:0]   target;
      logic                found;
      logic [SLOT_W-1:0]   found_slot;
      logic                recent_hit;
   } pkt_type;

   // Table status handed from the controller to the cells
   typedef struct packed {
      logic [CNT_W-1:0]  fill_count;
      logic              recent_valid;
      logic [SLOT_W-1:0] recent_slot;
      logic [SLOT_W-1:0] ins_slot;
   } ctx_type;

   typedef struct packed {
      logic                  hit;
      logic [OUT_SLOT_W-1:0] slot;
   } res_type;

endpackage

// File: sv/klcam_if.sv
// Request and response channel interfaces of the key list table.
// Depends on klcam_pkg for the field widths.
interface klcam_req_if import klcam_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           action;
   logic [LEN_W-1:0]     token_count;
   logic [TOKEN_W-1:0]   token_0;
   logic [TOKEN_W-1:0]   token_1;
   logic [TOKEN_W-1:0]   token_2;
   logic [TOKEN_W-1:0]   token_3;

   modport source (output valid, action, token_count, token_0, token_1, token_2, token_3,
                   input ready);
   modport sink   (input valid, action, token_count, token_0, token_1, token_2, token_3,
                   output ready);
endinterface

interface klcam_rsp_if import klcam_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [OUT_SLOT_W-1:0] slot;

   modport source (output valid, hit, slot, input ready);
   modport sink   (input valid, hit, slot, output ready);
endinterface

// File: sv/klcam_cell.sv
// One slot of the table: stored key plus one stage of the travelling packet.
// Depends on klcam_pkg.
module klcam_cell import klcam_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] idx,
   input  ctx_type           ctx,
   input  pkt_type           up_pkt,
   output pkt_type           dn_pkt
);

   key_type          tok_ff;
   logic [LEN_W-1:0] len_ff;
   pkt_type          pkt_ff;
   pkt_type          pkt_in;
   logic             filled;
   logic             match;
   logic             write_en;

   // Compare the passing key with this slot
   always_comb begin
      filled   = CNT_W'(idx) < ctx.fill_count;
      match    = filled && (len_ff == up_pkt.len) && (tok_ff == up_pkt.tokens);
      write_en = up_pkt.valid && (up_pkt.action == ACT_INSERT) && (up_pkt.target == idx);
   end

   // Mark the first match and a match on the recent slot
   always_comb begin
      pkt_in = up_pkt;
      if (up_pkt.valid && (up_pkt.action == ACT_LOOKUP)) begin
         if (match && !up_pkt.found) begin
            pkt_in.found      = 1'b1;
            pkt_in.found_slot = idx;
         end
         if (match && ctx.recent_valid && (ctx.recent_slot == idx)) begin
            pkt_in.recent_hit = 1'b1;
         end
      end
   end

   // Advance the packet to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff.valid <= 1'b0;
      end else begin
         pkt_ff <= pkt_in;
      end
   end

   // Store the key when an insert targets this slot
   always_ff @(posedge clock) begin
      if (write_en) begin
         tok_ff <= up_pkt.tokens;
         len_ff <= up_pkt.len;
      end
   end

   assign dn_pkt = pkt_ff;

endmodule

// File: sv/klcam_ctrl.sv
// Table status, item sequencing and response register of the key list table.
// Depends on klcam_pkg.
module klcam_ctrl import klcam_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  pkt_type exit_pkt,
   input  logic    rsp_ready,
   output logic    req_ready,
   output ctx_type ctx,
   output logic    rsp_valid,
   output res_type rsp_res
);

   state_type         st_ff, st_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [SLOT_W-1:0] evict_ff, evict_in;
   logic              recent_valid_ff, recent_valid_in;
   logic [SLOT_W-1:0] recent_slot_ff, recent_slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   res_type           rsp_res_ff, rsp_res_in;
   res_type           hold_ff, hold_in;
   res_type           fin;
   logic              rsp_free;
   logic              load_rsp;
   logic              load_hold;
   logic              full;

   assign full     = fill_ff == CNT_W'(MAX_ENTRIES);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_fire) st_in = ST_RUN;
         end
         ST_RUN: begin
            if (exit_pkt.valid) st_in = rsp_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Handshake and load controls
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      load_hold = 1'b0;
      case (st_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_RUN: begin
            load_rsp  = exit_pkt.valid && rsp_free;
            load_hold = exit_pkt.valid && !rsp_free;
         end
         ST_HOLD: load_rsp = rsp_ready;
         default: ;
      endcase
   end

   // Finish the item leaving the row: result and table status
   always_comb begin
      fill_in         = fill_ff;
      evict_in        = evict_ff;
      recent_valid_in = recent_valid_ff;
      recent_slot_in  = recent_slot_ff;
      fin             = '0;
      if (exit_pkt.valid) begin
         case (exit_pkt.action)
            ACT_LOOKUP: begin
               if (exit_pkt.recent_hit) begin
                  fin.hit  = 1'b1;
                  fin.slot = OUT_SLOT_W'(recent_slot_ff);
               end else if (exit_pkt.found) begin
                  fin.hit         = 1'b1;
                  fin.slot        = OUT_SLOT_W'(exit_pkt.found_slot);
                  recent_valid_in = 1'b1;
                  recent_slot_in  = exit_pkt.found_slot;
               end
            end
            ACT_INSERT: begin
               fin.hit  = 1'b1;
               fin.slot = OUT_SLOT_W'(exit_pkt.target);
               if (!full) begin
                  fill_in = fill_ff + CNT_W'(1);
               end else if (evict_ff == SLOT_W'(MAX_ENTRIES - 1)) begin
                  evict_in = '0;
               end else begin
                  evict_in = evict_ff + SLOT_W'(1);
               end
               recent_valid_in = 1'b1;
               recent_slot_in  = exit_pkt.target;
            end
            ACT_CLEAR: begin
               fill_in         = '0;
               recent_valid_in = 1'b0;
               recent_slot_in  = '0;
            end
            default: ;
         endcase
      end
   end

   // Response register and holding stage
   always_comb begin
      hold_in    = load_hold ? fin : hold_ff;
      rsp_res_in = rsp_res_ff;
      if (load_rsp) rsp_res_in = (st_ff == ST_HOLD) ? hold_ff : fin;
      if (load_rsp)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= ST_IDLE;
         fill_ff         <= '0;
         evict_ff        <= '0;
         recent_valid_ff <= 1'b0;
         recent_slot_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         st_ff           <= st_in;
         fill_ff         <= fill_in;
         evict_ff        <= evict_in;
         recent_valid_ff <= recent_valid_in;
         recent_slot_ff  <= recent_slot_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
      hold_ff    <= hold_in;
   end

   // Status for the cells and the insert target for the next item
   always_comb begin
      ctx.fill_count   = fill_ff;
      ctx.recent_valid = recent_valid_ff;
      ctx.recent_slot  = recent_slot_ff;
      ctx.ins_slot     = full ? evict_ff : SLOT_W'(fill_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_res_ff;

endmodule

// File: sv/key_list_cam_round_robin_top.sv
// After a request transfer the key packet walks the row of slot cells one cell per cycle,
// and the controller then registers its result as the response. The block takes no new
// request while one is in flight: the next request is taken once the previous packet has
// left the last cell and its result sits in the response register.
// Reset: synchronous; clears fill count, eviction pointer, recent mark and all
// valid flags. Slot contents stay undefined until written; no clearing pass.
module key_list_cam_round_robin_top import klcam_pkg::*; (
   input logic         clock,
   input logic         reset,
   klcam_req_if.sink   req_bus,
   klcam_rsp_if.source rsp_bus
);

   pkt_type                        link [MAX_ENTRIES+1];
   ctx_type                        ctx;
   res_type                        rsp_res;
   logic                           req_ready;
   logic                           req_fire;
   logic [LEN_W-1:0]               key_len;
   logic [IN_TOKENS-1:0][TOKEN_W-1:0] in_tok;
   key_type                        key;

   assign req_fire = req_bus.valid && req_ready;
   assign in_tok   = {req_bus.token_3, req_bus.token_2, req_bus.token_1, req_bus.token_0};

   // Saturate the key length
   assign key_len = (req_bus.token_count > LEN_W'(LEN_SAT)) ? LEN_W'(LEN_SAT)
                                                            : req_bus.token_count;

   // Zero the tokens beyond the key length
   for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_key
      if (i < IN_TOKENS) begin : g_in
         assign key[i] = (LEN_W'(i) < key_len) ? in_tok[i] : '0;
      end else begin : g_zero
         assign key[i] = '0;
      end
   end

   // Launch packet into the first cell
   always_comb begin
      link[0]            = '0;
      link[0].valid      = req_fire;
      link[0].action     = action_type'(req_bus.action);
      link[0].len        = key_len;
      link[0].tokens     = key;
      link[0].target     = ctx.ins_slot;
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      klcam_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .idx    (SLOT_W'(g)),
         .ctx    (ctx),
         .up_pkt (link[g]),
         .dn_pkt (link[g+1])
      );
   end

   klcam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .exit_pkt  (link[MAX_ENTRIES]),
      .rsp_ready (rsp_bus.ready),
      .req_ready (req_ready),
      .ctx       (ctx),
      .rsp_valid (rsp_bus.valid),
      .rsp_res   (rsp_res)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.hit   = rsp_res.hit;
   assign rsp_bus.slot  = rsp_res.slot;

endmodule

// File: sv/klcam_checker.sv
// Port-level checks of the key list table, bound to the top level.
// Depends on klcam_pkg.
module klcam_checker import klcam_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_hit,
   input logic [OUT_SLOT_W-1:0] rsp_slot
);

   logic [1:0] out_cnt_ff, out_cnt_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // Track items taken but not yet answered
   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (req_xfer && !rsp_xfer)      out_cnt_in = out_cnt_ff + 2'd1;
      else if (rsp_xfer && !req_xfer) out_cnt_in = out_cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) out_cnt_ff <= '0;
      else       out_cnt_ff <= out_cnt_in;
   end

   a_no_invented_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> out_cnt_ff != 2'd0)
      else $error("response without an outstanding request");

   a_bounded_outstanding: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("more than two requests outstanding");

   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_slot == '0)
      else $error("miss reported with a nonzero slot");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_slot))
      else $error("stalled response changed");

endmodule

bind key_list_cam_round_robin_top klcam_checker u_klcam_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_hit   (rsp_bus.hit),
   .rsp_slot  (rsp_bus.slot)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for key_list_cam_round_robin_top: directed and random traffic
// through the request and response channels, checked by a scoreboard class.
// Depends on klcam_pkg, klcam_if.sv and the top level of the block.
module tb_top import klcam_pkg::*; ();

   // Action code that the block must ignore
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int ITEMS_PER_PHASE = 490;
   localparam int POOL_SIZE       = 12;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_CYCLES    = 2 * MAX_ENTRIES + 4;

   typedef logic [IN_TOKENS-1:0][TOKEN_W-1:0] req_tokens_type;

   // Scoreboard: tracks the table contents and queues the expected responses
   class key_table_scoreboard;
      logic [TOKEN_W-1:0] slot_tokens [MAX_ENTRIES][MAX_TOKENS];
      int unsigned        slot_len [MAX_ENTRIES];
      int unsigned        fill_count;
      int unsigned        evict_ptr;
      int unsigned        recent_slot;
      bit                 recent_valid;
      res_type            pending_results[$];
      int unsigned        mismatches;
      int unsigned        checked;
      int unsigned        n_lookup, n_hit, n_insert, n_evict, n_clear, n_unused;

      function bit slot_matches(int unsigned s, key_type key, int unsigned len);
         if (slot_len[s] != len) return 1'b0;
         for (int i = 0; i < len && i < MAX_TOKENS; i++) begin
            if (slot_tokens[s][i] != key[i]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
      endfunction

      // Work out the response to one accepted request and queue it
      function void note_request(logic [1:0] act, logic [LEN_W-1:0] count,
                                 req_tokens_type tok);
         key_type     key;
         int unsigned len;
         int unsigned s;
         bit          hit;
         res_type     r;
         hit = 1'b0;
         s   = 0;
         // Saturate long keys and zero the unused token positions
         len = (count > MAX_TOKENS) ? MAX_TOKENS : count;
         for (int i = 0; i < MAX_TOKENS; i++) begin
            key[i] = (i < len && i < IN_TOKENS) ? tok[i] : '0;
         end
         case (act)
            ACT_LOOKUP: begin
               n_lookup++;
               // Try the recent slot first, then the lowest matching slot
               if (recent_valid && recent_slot < fill_count &&
                   slot_matches(recent_slot, key, len)) begin
                  hit = 1'b1;
                  s   = recent_slot;
               end else begin
                  for (int k = 0; k < fill_count && k < MAX_ENTRIES && !hit; k++) begin
                     if (slot_matches(k, key, len)) begin
                        hit          = 1'b1;
                        s            = k;
                        recent_valid = 1'b1;
                        recent_slot  = k;
                     end
                  end
               end
               if (hit) n_hit++;
            end
            ACT_INSERT: begin
               n_insert++;
               // Append while there is room, otherwise overwrite round-robin
               if (fill_count < MAX_ENTRIES) begin
                  s = fill_count;
                  fill_count++;
               end else begin
                  s         = evict_ptr % MAX_ENTRIES;
                  evict_ptr = (s + 1) % MAX_ENTRIES;
                  n_evict++;
               end
               for (int i = 0; i < MAX_TOKENS; i++) slot_tokens[s][i] = key[i];
               slot_len[s]  = len;
               recent_valid = 1'b1;
               recent_slot  = s;
               hit          = 1'b1;
            end
            ACT_CLEAR: begin
               n_clear++;
               // Eviction pointer survives a clear
               fill_count   = 0;
               recent_valid = 1'b0;
               recent_slot  = 0;
            end
            default: begin
               n_unused++;
            end
         endcase
         r.hit  = hit;
         r.slot = hit ? OUT_SLOT_W'(s) : '0;
         pending_results = {pending_results, r};
      endfunction

      // Compare one response transfer with the oldest expectation
      function void check_response(logic hit, logic [OUT_SLOT_W-1:0] slot);
         res_type want;
         checked++;
         if (pending_results.size() == 0) begin
            note_mismatch($sformatf("response hit=%0b slot=%0d with nothing pending",
                                    hit, slot));
            return;
         end
         want = pending_results.pop_front();
         if (hit !== want.hit || slot !== want.slot) begin
            note_mismatch($sformatf("expected hit=%0b slot=%0d, got hit=%0b slot=%0d",
                                    want.hit, want.slot, hit, slot));
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   klcam_req_if req_bus ();
   klcam_rsp_if rsp_bus ();

   key_list_cam_round_robin_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   key_table_scoreboard sb = new;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int stall_cycles  = 0;

   logic [TOKEN_W-1:0] pool_tok [POOL_SIZE][MAX_TOKENS];
   int unsigned        pool_len [POOL_SIZE];

   // Clock: 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hold every input at a known value from time zero
   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACT_LOOKUP;
      req_bus.token_count = '0;
      req_bus.token_0     = '0;
      req_bus.token_1     = '0;
      req_bus.token_2     = '0;
      req_bus.token_3     = '0;
      rsp_bus.ready       = 1'b0;
   end

   // Stall the response channel at the rate of the current phase
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check response transfers and watch for a hung handshake
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) sb.check_response(rsp_bus.hit, rsp_bus.slot);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles, %0d responses pending",
                     $realtime, stall_cycles, sb.pending_results.size());
            $display("FAIL key_list_cam_round_robin_top");
            $finish;
         end
      end
   end

   function automatic logic [TOKEN_W-1:0] random_token();
      return {$urandom, $urandom};
   endfunction

   // Present one request, wait for its transfer and note it
   task automatic send_request(logic [1:0] act, logic [LEN_W-1:0] count,
                               req_tokens_type tok);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.action      <= act;
      req_bus.token_count <= count;
      req_bus.token_0     <= tok[0];
      req_bus.token_1     <= tok[1];
      req_bus.token_2     <= tok[2];
      req_bus.token_3     <= tok[3];
      req_bus.valid       <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(act, count, tok);
      @(negedge clock);
   endtask

   task automatic send_key(logic [1:0] act, logic [LEN_W-1:0] count,
                           logic [TOKEN_W-1:0] t0, logic [TOKEN_W-1:0] t1,
                           logic [TOKEN_W-1:0] t2, logic [TOKEN_W-1:0] t3);
      send_request(act, count, {t3, t2, t1, t0});
   endtask

   // Fill the key pool; keys share leading tokens so near matches are common
   task automatic build_key_pool();
      logic [TOKEN_W-1:0] head_a, head_b, second;
      head_a = random_token();
      head_b = random_token();
      second = random_token();
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_len[k] = $urandom_range(MAX_TOKENS);
         for (int i = 0; i < MAX_TOKENS; i++) pool_tok[k][i] = random_token();
         pool_tok[k][0] = $urandom_range(1) ? head_a : head_b;
         if ($urandom_range(1)) pool_tok[k][1] = second;
      end
   endtask

   // Mostly inserts and lookups of pooled keys, the rest noise
   task automatic send_random_item();
      logic [1:0]       act;
      logic [LEN_W-1:0] count;
      req_tokens_type   tok;
      int               roll, k, pos, bitpos;
      roll = $urandom_range(99);
      k    = $urandom_range(POOL_SIZE - 1);
      for (int i = 0; i < IN_TOKENS; i++) tok[i] = random_token();
      if (roll < 80) begin
         act   = (roll < 46) ? ACT_LOOKUP : ACT_INSERT;
         count = LEN_W'(pool_len[k]);
         if (pool_len[k] == MAX_TOKENS && $urandom_range(3) == 0)
            count = LEN_W'($urandom_range(7, MAX_TOKENS));
         for (int i = 0; i < pool_len[k] && i < IN_TOKENS; i++) tok[i] = pool_tok[k][i];
         // Now and then look up a key that differs in one bit or in length
         if (act == ACT_LOOKUP && $urandom_range(9) == 0) begin
            if (pool_len[k] == 0) begin
               count = LEN_W'(1);
            end else begin
               pos           = $urandom_range(pool_len[k] - 1);
               bitpos        = $urandom_range(TOKEN_W - 1);
               tok[pos][bitpos] = ~tok[pos][bitpos];
            end
         end
      end else if (roll < 92) begin
         act   = $urandom_range(1) ? ACT_INSERT : ACT_LOOKUP;
         count = LEN_W'($urandom_range(7));
      end else if (roll < 96) begin
         act   = ACT_CLEAR;
         count = LEN_W'($urandom_range(7));
      end else begin
         act   = ACT_UNUSED;
         count = LEN_W'($urandom_range(7));
      end
      send_request(act, count, tok);
   endtask

   // Main sequence
   initial begin
      logic [TOKEN_W-1:0] ones, zeros;
      ones  = '1;
      zeros = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table, odd actions, saturation, recent slot and eviction
      send_key(ACT_LOOKUP, 0, ones, ones, ones, ones);
      send_key(ACT_CLEAR,  7, ones, ones, ones, ones);
      send_key(ACT_UNUSED, 4, ones, ones, ones, ones);
      send_key(ACT_INSERT, 0, ones, ones, ones, ones);
      send_key(ACT_LOOKUP, 0, zeros, zeros, zeros, zeros);
      send_key(ACT_INSERT, 4, ones, ones, ones, ones);
      send_key(ACT_LOOKUP, 7, ones, ones, ones, ones);
      send_key(ACT_INSERT, 5, zeros, zeros, zeros, zeros);
      send_key(ACT_LOOKUP, 4, zeros, zeros, zeros, zeros);
      send_key(ACT_INSERT, 4, ones, ones, ones, ones);
      send_key(ACT_LOOKUP, 4, ones, ones, ones, ones);
      send_key(ACT_LOOKUP, 0, ones, ones, ones, ones);
      send_key(ACT_LOOKUP, 4, ones, ones, ones, ones);
      send_key(ACT_LOOKUP, 4, ones, ones, ones, ones ^ 64'd1);
      send_key(ACT_LOOKUP, 3, ones, ones, ones, ones);
      for (int n = 1; n <= 4; n++)
         send_key(ACT_INSERT, LEN_W'(n), random_token(), random_token(), random_token(),
                  random_token());
      send_key(ACT_UNUSED, 2, zeros, zeros, zeros, zeros);
      send_key(ACT_INSERT, 2, random_token(), random_token(), zeros, zeros);
      send_key(ACT_INSERT, 1, random_token(), zeros, zeros, zeros);
      send_key(ACT_CLEAR,  0, zeros, zeros, zeros, zeros);
      send_key(ACT_LOOKUP, 4, ones, ones, ones, ones);
      send_key(ACT_INSERT, 4, ones, ones, ones, ones);

      // Random: no idling, idle sender, stalling receiver, then both
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 73; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 73; end
            default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
         endcase
         build_key_pool();
         repeat (ITEMS_PER_PHASE) send_random_item();
      end
      req_bus.valid <= 1'b0;

      // Drain outstanding responses, then allow for anything stray
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d lookups (%0d hits), %0d inserts (%0d overwrites),",
               sb.n_lookup + sb.n_insert + sb.n_clear + sb.n_unused, sb.n_lookup, sb.n_hit,
               sb.n_insert, sb.n_evict);
      $display("%0d clears, %0d unused actions; %0d responses checked, %0d mismatches",
               sb.n_clear, sb.n_unused, sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("PASS key_list_cam_round_robin_top");
      end else begin
         $display("FAIL key_list_cam_round_robin_top");
      end
      $finish;
   end

endmodule

// File: key_list_cam_round_robin_top.f
sv/klcam_pkg.sv
sv/klcam_if.sv
sv/klcam_cell.sv
sv/klcam_ctrl.sv
sv/key_list_cam_round_robin_top.sv
sv/klcam_checker.sv
test/tb_top.sv
